/* rtl/core/pwq_pkg.sv */
// Shared types and constants for the priority wait queue.
// Used by the queue top level; the storage RAM is generic and takes none of it.
`default_nettype none
package pwq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 8;
   localparam int IDX_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_BITS  = ID_BITS + 16;

   typedef enum logic [1:0] {
      ACT_ENQUEUE = 2'd0,
      ACT_DEQUEUE = 2'd1,
      ACT_UNLINK  = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_DUPLICATE = 3'd4
   } status_type;

   typedef struct packed {
      logic [ID_BITS-1:0] id;
      logic [7:0]         base_pri;
      logic [7:0]         user_pri;
   } entry_type;

endpackage
`default_nettype wire

/* rtl/core/pwq_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing; width and depth are parameters.
`default_nettype none
module pwq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output      logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

/* rtl/core/priority_wait_queue.sv */
// Priority wait queue: sorted waiter list held in one RAM, walked by a sequencer.
// Depends on pwq_pkg and pwq_ram.
`default_nettype none
// A request carries an action (enqueue, dequeue head, unlink by id) and one
// response comes back per request with the removed id, a status and the
// count left queued. Entries sit sorted in a single RAM with one read and
// one write port, so each request walks it. First comes a scan of all N
// queued entries. Then, for an insert or a removal, the c entries behind the
// affected slot shift one per cycle. Last, the response is posted once the
// output register is free. The next request is taken once the previous
// response has been loaded into the output register.
module priority_wait_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [7:0] waiter_id, [15:8] base_priority, [23:16] user_priority
   input  wire logic [23:0] req_tdata,
   // [1:0] action
   input  wire logic [1:0]  req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] served_id, [10:8] status, [15:11] waiting_count
   output      logic [15:0] rsp_tdata
);
   import pwq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_SHUP, S_SHDN, S_DONE
   } state_type;

   state_type              state_ff, state_in;
   action_type             act_ff, act_in;
   entry_type              op_ff, op_in;
   logic [CNT_BITS-1:0]    occ_ff, occ_in;
   logic [CNT_BITS-1:0]    rd_idx_ff, rd_idx_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [IDX_BITS-1:0]    chk_idx_ff, chk_idx_in;
   logic                   found_ff, found_in;
   logic [IDX_BITS-1:0]    found_pos_ff, found_pos_in;
   logic                   ins_found_ff, ins_found_in;
   logic [IDX_BITS-1:0]    ins_pos_ff, ins_pos_in;
   logic [ID_BITS-1:0]     head_id_ff, head_id_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [IDX_BITS-1:0]    src_ff, src_in;
   logic                   pend_vld_ff, pend_vld_in;
   logic [IDX_BITS-1:0]    pend_dst_ff, pend_dst_in;
   status_type             res_status_ff, res_status_in;
   logic [7:0]             res_served_ff, res_served_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [15:0]            rsp_data_ff, rsp_data_in;

   logic                   ram_we;
   logic [IDX_BITS-1:0]    ram_waddr;
   logic [ENTRY_BITS-1:0]  ram_wdata;
   logic [IDX_BITS-1:0]    ram_raddr;
   logic [ENTRY_BITS-1:0]  ram_rdata;
   entry_type              rd_entry;
   logic                   issue;
   logic                   beats;

   pwq_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_entry   = entry_type'(ram_rdata);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // new key sorts ahead of the entry being read
   assign beats = (op_ff.base_pri < rd_entry.base_pri) ||
                  ((op_ff.base_pri == rd_entry.base_pri) &&
                   (op_ff.user_pri < rd_entry.user_pri));

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      op_in         = op_ff;
      occ_in        = occ_ff;
      rd_idx_in     = rd_idx_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      found_in      = found_ff;
      found_pos_in  = found_pos_ff;
      ins_found_in  = ins_found_ff;
      ins_pos_in    = ins_pos_ff;
      head_id_in    = head_id_ff;
      cnt_in        = cnt_ff;
      src_in        = src_ff;
      pend_vld_in   = pend_vld_ff;
      pend_dst_in   = pend_dst_ff;
      res_status_in = res_status_ff;
      res_served_in = res_served_ff;
      rsp_vld_in    = rsp_vld_ff;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = pend_dst_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = src_ff;
      issue         = 1'b0;

      // drop the response once taken
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               act_in          = action_type'(req_tuser);
               op_in.id        = ID_BITS'(req_tdata[7:0]);
               op_in.base_pri  = req_tdata[15:8];
               op_in.user_pri  = req_tdata[23:16];
               rd_idx_in       = '0;
               chk_vld_in      = 1'b0;
               found_in        = 1'b0;
               ins_found_in    = 1'b0;
               res_served_in   = '0;
               res_status_in   = ST_OK;
               state_in        = S_SCAN;
            end
         end

         S_SCAN: begin
            // issue one read a cycle over the queued entries
            issue      = (rd_idx_ff < occ_ff);
            ram_raddr  = rd_idx_ff[IDX_BITS-1:0];
            chk_vld_in = issue;
            chk_idx_in = rd_idx_ff[IDX_BITS-1:0];
            if (issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            // check the entry that came back
            if (chk_vld_ff) begin
               if (chk_idx_ff == '0) begin
                  head_id_in = rd_entry.id;
               end
               if (!found_ff && (rd_entry.id == op_ff.id)) begin
                  found_in     = 1'b1;
                  found_pos_in = chk_idx_ff;
               end
               if (!ins_found_ff && beats) begin
                  ins_found_in = 1'b1;
                  ins_pos_in   = chk_idx_ff;
               end
            end
            // scan finished: decide
            if (!issue && !chk_vld_ff) begin
               pend_vld_in = 1'b0;
               unique case (act_ff)
                  ACT_ENQUEUE: begin
                     if (found_ff) begin
                        res_status_in = ST_DUPLICATE;
                        state_in      = S_DONE;
                     end else if (occ_ff == CNT_BITS'(QUEUE_DEPTH)) begin
                        res_status_in = ST_FULL;
                        state_in      = S_DONE;
                     end else begin
                        if (!ins_found_ff) begin
                           ins_pos_in = occ_ff[IDX_BITS-1:0];
                           cnt_in     = '0;
                        end else begin
                           cnt_in = occ_ff - CNT_BITS'(ins_pos_ff);
                        end
                        src_in   = IDX_BITS'(occ_ff - 1'b1);
                        state_in = S_SHUP;
                     end
                  end
                  ACT_DEQUEUE: begin
                     if (occ_ff == '0) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        res_served_in = 8'(head_id_ff);
                        cnt_in        = occ_ff - 1'b1;
                        src_in        = IDX_BITS'(1);
                        state_in      = S_SHDN;
                     end
                  end
                  ACT_UNLINK: begin
                     if (!found_ff) begin
                        res_status_in = ST_NOT_FOUND;
                        state_in      = S_DONE;
                     end else begin
                        res_served_in = 8'(op_ff.id);
                        cnt_in        = occ_ff - 1'b1 - CNT_BITS'(found_pos_ff);
                        src_in        = found_pos_ff + 1'b1;
                        state_in      = S_SHDN;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_SHUP: begin
            // move entries one slot back, from the tail toward the insert point
            issue       = (cnt_ff != '0);
            ram_raddr   = src_ff;
            ram_we      = pend_vld_ff;
            pend_vld_in = issue;
            pend_dst_in = src_ff + 1'b1;
            if (issue) begin
               cnt_in = cnt_ff - 1'b1;
               src_in = src_ff - 1'b1;
            end
            // place the new entry
            if (!issue && !pend_vld_ff) begin
               ram_we    = 1'b1;
               ram_waddr = ins_pos_ff;
               ram_wdata = ENTRY_BITS'(op_ff);
               occ_in    = occ_ff + 1'b1;
               state_in  = S_DONE;
            end
         end

         S_SHDN: begin
            // close the gap, moving entries one slot forward
            issue       = (cnt_ff != '0);
            ram_raddr   = src_ff;
            ram_we      = pend_vld_ff;
            pend_vld_in = issue;
            pend_dst_in = src_ff - 1'b1;
            if (issue) begin
               cnt_in = cnt_ff - 1'b1;
               src_in = src_ff + 1'b1;
            end
            if (!issue && !pend_vld_ff) begin
               occ_in   = occ_ff - 1'b1;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // load the response when the output register is free
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {5'(occ_ff), res_status_ff, res_served_ff};
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         occ_ff      <= '0;
         chk_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         occ_ff      <= occ_in;
         chk_vld_ff  <= chk_vld_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      act_ff        <= act_in;
      op_ff         <= op_in;
      rd_idx_ff     <= rd_idx_in;
      chk_idx_ff    <= chk_idx_in;
      found_ff      <= found_in;
      found_pos_ff  <= found_pos_in;
      ins_found_ff  <= ins_found_in;
      ins_pos_ff    <= ins_pos_in;
      head_id_ff    <= head_id_in;
      cnt_ff        <= cnt_in;
      src_ff        <= src_in;
      pend_dst_ff   <= pend_dst_in;
      res_status_ff <= res_status_in;
      res_served_ff <= res_served_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule
`default_nettype wire

/* tb/priority_wait_queue_test.sv */
// Self-checking test of the priority wait queue: sorted enqueue, dequeue, unlink.
// Depends on pwq_pkg and the priority_wait_queue RTL.
`timescale 1ns / 1ps

class WaitQueueScoreboard;
   pwq_pkg::entry_type slots[$];
   logic [15:0] pending_rsp[$];
   int errors;
   int checked;

   function int locate(logic [7:0] id);
      foreach (slots[i]) begin
         if (slots[i].id == id) return i;
      end
      return -1;
   endfunction

   // Update the shadow queue for one request and note its response.
   function void note_request(pwq_pkg::action_type act, logic [23:0] data);
      pwq_pkg::entry_type ent;
      pwq_pkg::status_type st;
      logic [7:0] served;
      int pos;
      ent.id = data[7:0];
      ent.base_pri = data[15:8];
      ent.user_pri = data[23:16];
      st = pwq_pkg::ST_OK;
      served = 8'd0;
      case (act)
         pwq_pkg::ACT_ENQUEUE: begin
            if (locate(ent.id) >= 0) st = pwq_pkg::ST_DUPLICATE;
            else if (slots.size() >= pwq_pkg::QUEUE_DEPTH) st = pwq_pkg::ST_FULL;
            else begin
               pos = slots.size();
               foreach (slots[i]) begin
                  if (ent.base_pri < slots[i].base_pri ||
                      (ent.base_pri == slots[i].base_pri &&
                       ent.user_pri < slots[i].user_pri)) begin
                     pos = i;
                     break;
                  end
               end
               slots.insert(pos, ent);
            end
         end
         pwq_pkg::ACT_DEQUEUE: begin
            if (slots.size() == 0) st = pwq_pkg::ST_EMPTY;
            else served = slots.pop_front().id;
         end
         pwq_pkg::ACT_UNLINK: begin
            pos = locate(ent.id);
            if (pos < 0) st = pwq_pkg::ST_NOT_FOUND;
            else begin
               served = slots[pos].id;
               slots.delete(pos);
            end
         end
         default: ;
      endcase
      pending_rsp.push_back({5'(slots.size()), st, served});
   endfunction

   task report(string what, logic [15:0] got, logic [15:0] want);
      $display("MISMATCH %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   // Compare one response with the oldest expectation, field by field.
   task check_response(logic [15:0] got);
      logic [15:0] want;
      checked++;
      if (pending_rsp.size() == 0) begin
         report("unexpected response", got, 16'h0);
         return;
      end
      want = pending_rsp.pop_front();
      if (got[7:0] !== want[7:0]) report("served_id", got, want);
      if (got[10:8] !== want[10:8]) report("status", got, want);
      if (got[15:11] !== want[15:11]) report("waiting_count", got, want);
   endtask
endclass

module priority_wait_queue_test;
   import pwq_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [7:0] waiter_id, [15:8] base_priority, [23:16] user_priority
   logic [23:0] req_tdata = '0;
   // [1:0] action
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [7:0] served_id, [10:8] status, [15:11] waiting_count
   logic [15:0] rsp_tdata;

   WaitQueueScoreboard board;
   int idle_cycles;
   int sent;
   bit rsp_stall_on;
   localparam int WATCHDOG_LIMIT = 20000;

   priority_wait_queue DUT (.*);

   always #5 clock = ~clock;

   function int gap_length();
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
      return $urandom_range(5, 40);
   endfunction

   // Hold one request until the block takes it, then predict its response.
   task send_request(action_type act, logic [7:0] id, logic [7:0] bp, logic [7:0] up,
                     bit gaps);
      int g;
      g = gaps ? gap_length() : 0;
      repeat (g + 1) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {up, bp, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(act, {up, bp, id});
      sent++;
      req_tvalid <= 1'b0;
   endtask

   // Drain the response side, with random stalls once they are switched on.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
         if (!rsp_stall_on) rsp_tready <= 1'b1;
         else if ($urandom_range(0, 9) < 3) rsp_tready <= 1'b0;
         else rsp_tready <= ($urandom_range(0, 19) != 0);
      end
   end

   // Watchdog: end the run after a long stretch with no handshake.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout after %0d idle cycles", idle_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   function logic [7:0] random_id();
      // narrow id pool keeps duplicates and hits frequent
      if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 23));
      return 8'($urandom);
   endfunction

   task wait_drained();
      while (board.pending_rsp.size() != 0) @(posedge clock);
   endtask

   initial begin
      int kind;
      int pick;
      board = new();
      idle_cycles = 0;
      sent = 0;
      rsp_stall_on = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty cases, extremes, ties, fill to full, duplicates.
      send_request(ACT_DEQUEUE, 8'd0, 8'd0, 8'd0, 0);
      send_request(ACT_UNLINK, 8'd5, 8'd0, 8'd0, 0);
      send_request(ACT_NONE, 8'hFF, 8'hFF, 8'hFF, 0);
      send_request(ACT_ENQUEUE, 8'hFF, 8'hFF, 8'hFF, 0);
      send_request(ACT_ENQUEUE, 8'h00, 8'h00, 8'h00, 0);
      send_request(ACT_ENQUEUE, 8'h00, 8'h10, 8'h10, 0);
      for (int i = 1; i < 15; i++)
         send_request(ACT_ENQUEUE, 8'(i), 8'h80, 8'(i % 3), 0);
      send_request(ACT_ENQUEUE, 8'hAA, 8'h00, 8'h00, 0);
      send_request(ACT_UNLINK, 8'h07, 8'h00, 8'h00, 0);
      send_request(ACT_UNLINK, 8'hFF, 8'h00, 8'h00, 0);
      send_request(ACT_DEQUEUE, 8'h00, 8'h00, 8'h00, 0);
      send_request(ACT_NONE, 8'h00, 8'h00, 8'h00, 0);
      wait_drained();

      // Random: mostly valid traffic, biased by occupancy, with stalls.
      rsp_stall_on = 1'b1;
      for (int n = 0; n < 900; n++) begin
         if (n == 450) wait_drained();
         kind = $urandom_range(0, 99);
         if (kind < 3) send_request(ACT_NONE, 8'($urandom), 8'($urandom), 8'($urandom), 1);
         else if (kind < 50 - (board.slots.size() - 8) * 3)
            send_request(ACT_ENQUEUE, random_id(), ($urandom_range(0, 1) ?
                         8'($urandom_range(0, 3)) : 8'($urandom)),
                         ($urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom)), 1);
         else if (kind < 75) send_request(ACT_DEQUEUE, 8'($urandom), 8'($urandom),
                                          8'($urandom), 1);
         else begin
            pick = (board.slots.size() > 0 && $urandom_range(0, 3) != 0) ?
                   board.slots[$urandom_range(0, board.slots.size() - 1)].id : random_id();
            send_request(ACT_UNLINK, 8'(pick), 8'($urandom), 8'($urandom), 1);
         end
      end
      wait_drained();
      repeat (50) @(posedge clock);
      $display("Covered %0d requests and %0d responses across empty, full, tie and unlink cases",
               sent, board.checked);
      if (board.errors == 0 && board.pending_rsp.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

/* priority_wait_queue.f */
rtl/core/pwq_pkg.sv
rtl/core/pwq_ram.sv
rtl/core/priority_wait_queue.sv
tb/priority_wait_queue_test.sv
